// ----- rtl/lds_pkg.sv -----
package lds_pkg;

	// Field widths
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int LIGHT_W = 12;
	localparam int POWER_W = 7;
	localparam int PWM_W   = 16;
	localparam int DAC_W   = 11;
	localparam int STEP_W  = 4;
	localparam int DAY_W   = 11;
	localparam int DUR_W   = 11;
	localparam int MODE_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 55;

	// Schedule geometry
	localparam int TABLE_SLOTS     = 10;
	localparam int HALF_SLOTS      = 5;
	localparam int SEGMENTS        = 10;
	localparam int MINUTES_PER_DAY = 1440;
	localparam int PWR_TABLE_W     = POWER_W * HALF_SLOTS;
	localparam int DUR_TABLE_W     = DUR_W * HALF_SLOTS;
	localparam int HOURS           = 32;
	localparam int MINUTES_PER_HOUR = 60;

	localparam logic [STEP_W-1:0] WAIT_STEP = STEP_W'(10);

	// Light hysteresis and drive scaling
	localparam int LIGHT_ON_LEVEL  = 1000;
	localparam int LIGHT_OFF_LEVEL = 920;
	localparam int POWER_MAX       = 100;
	localparam int PWM_FULL        = 50000;
	localparam int PWM_STEP        = 500;
	localparam int DAC_STEP        = 20;

	typedef enum logic [MODE_W-1:0] {
		MODE_AUTO   = 2'd0,
		MODE_MANUAL = 2'd1,
		MODE_TIMED  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WORK_MODE      = 3'd0,
		CFG_MANUAL_POWER   = 3'd1,
		CFG_POWER_FIRST    = 3'd2,
		CFG_POWER_SECOND   = 3'd3,
		CFG_DURATION_FIRST = 3'd4,
		CFG_DURATION_SECOND = 3'd5,
		CFG_END_HOUR       = 3'd6,
		CFG_END_MINUTE     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		mode_t                    work_mode;
		logic [POWER_W-1:0]       manual_power;
		logic [PWR_TABLE_W-1:0]   power_first;
		logic [PWR_TABLE_W-1:0]   power_second;
		logic [DUR_TABLE_W-1:0]   duration_first;
		logic [DUR_TABLE_W-1:0]   duration_second;
		logic [HOUR_W-1:0]        end_hour;
		logic [MIN_W-1:0]         end_minute;
	} lds_cfg_t;

	typedef struct packed {
		logic [STEP_W-1:0]  step;
		logic               running;
		logic [DAY_W-1:0]   start_minute;
		logic               lamp;
		logic [POWER_W-1:0] power;
		logic [POWER_W-1:0] drive;
	} lds_state_t;

endpackage

// ----- rtl/lamp_dimming_schedule_controller.sv -----
// Lamp dimming and schedule controller. Each input beat is one clock tick
// (hour, minute, light level, schedule arm) and gives exactly one result
// beat with the lamp power, PWM compare, DAC level, relay state, current
// segment and schedule status. A beat is taken every cycle unless stalled: it
// lands in an input register, one pass of combinational logic updates the
// controller state, and the result register, which is also the state, holds
// the result until the output side takes it. The rate of one beat per cycle,
// when unstalled, is set by that single state-update path. The user must
// write the configuration registers through their own port, one register per
// beat, only while no tick is in flight; the block does not enforce this.
module lamp_dimming_schedule_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	// tick channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lds_pkg::HOUR_W-1:0]      clock_hour,
	input  logic [lds_pkg::MIN_W-1:0]       clock_minute,
	input  logic [lds_pkg::LIGHT_W-1:0]     light_level,
	input  logic                            start_schedule,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lds_pkg::POWER_W-1:0]     lamp_power,
	output logic [lds_pkg::PWM_W-1:0]       pwm_compare,
	output logic [lds_pkg::DAC_W-1:0]       dac_level,
	output logic                            lamp_on,
	output logic [lds_pkg::STEP_W-1:0]      segment_index,
	output logic                            schedule_active,
	// configuration channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lds_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lds_pkg::*;

	lds_cfg_t   cfg;
	lds_state_t state_q;
	lds_state_t state_next;

	logic               valid_s1;
	logic [HOUR_W-1:0]  hour_s1;
	logic [MIN_W-1:0]   minute_s1;
	logic [LIGHT_W-1:0] light_s1;
	logic               arm_s1;

	logic               out_valid_q;
	logic [PWM_W-1:0]   pwm_q;
	logic [DAC_W-1:0]   dac_q;
	logic [PWM_W-1:0]   pwm_next;
	logic [DAC_W-1:0]   dac_next;
	logic               advance;
	logic               in_take;

	assign cfg_ready = 1'b1;

	lds_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lds_step u_step (
		.cfg    (cfg),
		.cur    (state_q),
		.hour   (hour_s1),
		.minute (minute_s1),
		.light  (light_s1),
		.arm    (arm_s1),
		.nxt    (state_next)
	);

	// The result register moves when it is empty or its beat is being taken.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			hour_s1   <= clock_hour;
			minute_s1 <= clock_minute;
			light_s1  <= light_level;
			arm_s1    <= start_schedule;
		end
	end

	// Drive scaling from the new drive power.
	assign pwm_next = PWM_W'(PWM_FULL) - PWM_W'(PWM_STEP) * PWM_W'(state_next.drive);
	assign dac_next = DAC_W'(DAC_STEP) * DAC_W'(state_next.drive);

	// State doubles as the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			state_q     <= '{step: WAIT_STEP, default: '0};
			pwm_q       <= PWM_W'(PWM_FULL);
			dac_q       <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
				pwm_q   <= pwm_next;
				dac_q   <= dac_next;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign lamp_power      = state_q.power;
	assign pwm_compare     = pwm_q;
	assign dac_level       = dac_q;
	assign lamp_on         = state_q.lamp;
	assign segment_index   = state_q.step;
	assign schedule_active = state_q.running;

	// The step is always a real segment or the waiting code.
	a_step_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (segment_index < STEP_W'(SEGMENTS) || segment_index == WAIT_STEP))
		else $error("segment index out of range");

	// Nonzero reported power only with the relay closed, and never above full.
	a_power_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((lamp_power == '0 || lamp_on) && lamp_power <= POWER_W'(POWER_MAX)))
		else $error("reported power inconsistent with lamp state");

	// PWM and DAC always come from the same drive power.
	a_drive_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(pwm_compare) + 32'(dac_level) * 32'(PWM_STEP / DAC_STEP)
			== 32'(PWM_FULL)))
		else $error("PWM compare and DAC level disagree");

	// The input side only waits while a tick is held in the input register.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with nothing held");

endmodule

// ----- rtl/lds_cfg_regs.sv -----
module lds_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [lds_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [lds_pkg::CFG_DATA_W-1:0]  wr_data,
	output lds_pkg::lds_cfg_t               cfg
);
	import lds_pkg::*;

	lds_cfg_t cfg_q;

	// Register file, one register per index, all cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_WORK_MODE:       cfg_q.work_mode <= mode_t'(wr_data[MODE_W-1:0]);
				CFG_MANUAL_POWER:    cfg_q.manual_power <= wr_data[POWER_W-1:0];
				CFG_POWER_FIRST:     cfg_q.power_first <= wr_data[PWR_TABLE_W-1:0];
				CFG_POWER_SECOND:    cfg_q.power_second <= wr_data[PWR_TABLE_W-1:0];
				CFG_DURATION_FIRST:  cfg_q.duration_first <= wr_data[DUR_TABLE_W-1:0];
				CFG_DURATION_SECOND: cfg_q.duration_second <= wr_data[DUR_TABLE_W-1:0];
				CFG_END_HOUR:        cfg_q.end_hour <= wr_data[HOUR_W-1:0];
				CFG_END_MINUTE:      cfg_q.end_minute <= wr_data[MIN_W-1:0];
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/lds_step.sv -----
module lds_step (
	input  lds_pkg::lds_cfg_t               cfg,
	input  lds_pkg::lds_state_t             cur,
	input  logic [lds_pkg::HOUR_W-1:0]      hour,
	input  logic [lds_pkg::MIN_W-1:0]       minute,
	input  logic [lds_pkg::LIGHT_W-1:0]     light,
	input  logic                            arm,
	output lds_pkg::lds_state_t             nxt
);
	import lds_pkg::*;

	localparam logic [DAY_W:0] DAY_LEN = (DAY_W + 1)'(MINUTES_PER_DAY);

	logic [DAY_W-1:0]   hour_mod [HOURS];
	logic [POWER_W-1:0] seg_pw   [TABLE_SLOTS];
	logic [DUR_W-1:0]   seg_dur  [TABLE_SLOTS];

	logic [DAY_W:0]     day_sum;
	logic [DAY_W:0]     day_red;
	logic [DAY_W-1:0]   now;
	logic [DAY_W:0]     elapsed;
	logic [POWER_W-1:0] seg_power_sat;
	logic [POWER_W-1:0] manual_sat;
	logic [STEP_W:0]    step_inc;

	// Hour offsets into the day, reduced at elaboration.
	for (genvar h = 0; h < HOURS; h++) begin : g_hour
		localparam int HOUR_OFS = (h * MINUTES_PER_HOUR) % MINUTES_PER_DAY;
		assign hour_mod[h] = DAY_W'(HOUR_OFS);
	end

	// Unpack the segment tables.
	for (genvar s = 0; s < HALF_SLOTS; s++) begin : g_seg
		assign seg_pw[s]               = cfg.power_first[s*POWER_W +: POWER_W];
		assign seg_pw[s+HALF_SLOTS]    = cfg.power_second[s*POWER_W +: POWER_W];
		assign seg_dur[s]              = cfg.duration_first[s*DUR_W +: DUR_W];
		assign seg_dur[s+HALF_SLOTS]   = cfg.duration_second[s*DUR_W +: DUR_W];
	end

	// Minute of day: the hour part is already reduced, so the minute can push
	// the sum over the day length at most once.
	always_comb begin
		day_sum = {1'b0, hour_mod[hour]} + (DAY_W + 1)'(minute);
		day_red = (day_sum >= DAY_LEN) ? day_sum - DAY_LEN : day_sum;
		now     = day_red[DAY_W-1:0];
	end

	// Minutes since the segment started, wrapping at the end of the day.
	always_comb begin
		if (now >= cur.start_minute) begin
			elapsed = {1'b0, now} - {1'b0, cur.start_minute};
		end else begin
			elapsed = {1'b0, now} + DAY_LEN - {1'b0, cur.start_minute};
		end
	end

	assign manual_sat = (cfg.manual_power > POWER_W'(POWER_MAX)) ?
		POWER_W'(POWER_MAX) : cfg.manual_power;
	assign seg_power_sat = (seg_pw[cur.step] > POWER_W'(POWER_MAX)) ?
		POWER_W'(POWER_MAX) : seg_pw[cur.step];
	assign step_inc = {1'b0, cur.step} + (STEP_W + 1)'(1);

	// One tick of the controller.
	always_comb begin
		nxt = cur;
		if (arm) begin
			nxt.running = 1'b1;
		end

		unique case (cfg.work_mode)
			MODE_AUTO: begin
				if (light > LIGHT_W'(LIGHT_ON_LEVEL)) begin
					nxt.lamp = 1'b1;
				end
				if (light < LIGHT_W'(LIGHT_OFF_LEVEL)) begin
					nxt.lamp = 1'b0;
				end
			end
			MODE_MANUAL: begin
				nxt.power = manual_sat;
				nxt.drive = manual_sat;
				nxt.lamp  = (manual_sat != '0);
			end
			MODE_TIMED: begin
				// Stop time reached: end the schedule before stepping it.
				if (hour >= cfg.end_hour && minute >= cfg.end_minute) begin
					nxt.running = 1'b0;
					nxt.step    = WAIT_STEP;
				end
				if (nxt.running) begin
					if (nxt.step == WAIT_STEP) begin
						// Waiting: latch the start and begin once past midnight hour.
						nxt.start_minute = now;
						nxt.step = (hour == '0) ? WAIT_STEP : '0;
					end else if (nxt.step < STEP_W'(SEGMENTS)) begin
						nxt.power = seg_power_sat;
						nxt.drive = seg_power_sat;
						nxt.lamp  = (seg_power_sat != '0);
						if (elapsed >= (DAY_W + 1)'(seg_dur[cur.step])) begin
							nxt.start_minute = now;
							if (step_inc >= (STEP_W + 1)'(SEGMENTS)) begin
								nxt.step    = WAIT_STEP;
								nxt.running = 1'b0;
							end else begin
								nxt.step = step_inc[STEP_W-1:0];
							end
						end
					end else begin
						// Out-of-range step goes back to waiting.
						nxt.step         = WAIT_STEP;
						nxt.start_minute = now;
					end
				end
			end
			MODE_NONE: begin
			end
		endcase

		// Reported power reads zero while the lamp is off.
		if (!nxt.lamp) begin
			nxt.power = '0;
		end
	end

endmodule

// ----- verif/tb_lamp_dimming_schedule_controller.sv -----
module tb_lamp_dimming_schedule_controller;
	import lds_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 4;

	// Kinds of schedule programming used by the random part.
	typedef enum int {
		SCHED_RANDOM,
		SCHED_ALL_MAX,
		SCHED_ALL_MIN
	} sched_flavor_t;

	// One expected result beat.
	typedef struct packed {
		logic [POWER_W-1:0] lamp_power;
		logic [PWM_W-1:0]   pwm_compare;
		logic [DAC_W-1:0]   dac_level;
		logic               lamp_on;
		logic [STEP_W-1:0]  segment_index;
		logic               schedule_active;
	} lamp_report_t;

	logic                  clk;
	logic                  arst_n         = 1'b0;
	logic                  in_valid       = 1'b0;
	logic                  in_stall;
	logic [HOUR_W-1:0]     clock_hour     = '0;
	logic [MIN_W-1:0]      clock_minute   = '0;
	logic [LIGHT_W-1:0]    light_level    = '0;
	logic                  start_schedule = 1'b0;
	logic                  out_valid;
	logic                  out_stall      = 1'b0;
	logic [POWER_W-1:0]    lamp_power;
	logic [PWM_W-1:0]      pwm_compare;
	logic [DAC_W-1:0]      dac_level;
	logic                  lamp_on;
	logic [STEP_W-1:0]     segment_index;
	logic                  schedule_active;
	logic                  cfg_valid      = 1'b0;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index      = CFG_WORK_MODE;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;

	// Register copies kept by the predictor.
	mode_t                  cfg_mode;
	logic [POWER_W-1:0]     cfg_manual;
	logic [PWR_TABLE_W-1:0] cfg_power_first;
	logic [PWR_TABLE_W-1:0] cfg_power_second;
	logic [DUR_TABLE_W-1:0] cfg_duration_first;
	logic [DUR_TABLE_W-1:0] cfg_duration_second;
	logic [HOUR_W-1:0]      cfg_end_hour;
	logic [MIN_W-1:0]       cfg_end_minute;

	// Controller state kept by the predictor.
	logic [STEP_W-1:0]  ctl_step;
	logic               ctl_running;
	logic [DAY_W-1:0]   ctl_start_minute;
	logic               ctl_lamp;
	logic [POWER_W-1:0] ctl_power;
	logic [POWER_W-1:0] ctl_drive;

	lamp_report_t pending_reports[$];
	lamp_report_t oldest_report;
	int           error_count   = 0;
	int           cycle_count   = 0;
	int           src_idle_pct  = 0;
	int           sink_stall_pct = 0;
	int           hold_request  = 0;
	int           day_minute    = 0;

	int SRC_IDLE_PCT[4]   = '{0, 67, 0, 24};
	int SINK_STALL_PCT[4] = '{0, 0, 67, 24};

	lamp_dimming_schedule_controller u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.clock_hour      (clock_hour),
		.clock_minute    (clock_minute),
		.light_level     (light_level),
		.start_schedule  (start_schedule),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.lamp_power      (lamp_power),
		.pwm_compare     (pwm_compare),
		.dac_level       (dac_level),
		.lamp_on         (lamp_on),
		.segment_index   (segment_index),
		.schedule_active (schedule_active),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Cycle budget for the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Output stall: a requested hold-off first, random stalling otherwise.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			out_stall <= 1'b1;
			hold_request = hold_request - 1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// Saturate a power and drive the lamp with it.
	function automatic void apply_drive(int unsigned level);
		if (level > POWER_MAX)
			level = POWER_MAX;
		ctl_power = level;
		ctl_drive = level;
		ctl_lamp  = (level != 0);
	endfunction

	// Advance the controller by one tick and return the result it reports.
	function automatic lamp_report_t predict_tick(logic [HOUR_W-1:0] hour,
			logic [MIN_W-1:0] minute, logic [LIGHT_W-1:0] light, logic arm);
		int unsigned  now;
		int unsigned  elapsed;
		int unsigned  slot;
		int unsigned  seg_minutes;
		lamp_report_t r;
		now = (hour * MINUTES_PER_HOUR + minute) % MINUTES_PER_DAY;
		if (arm)
			ctl_running = 1'b1;
		case (cfg_mode)
		MODE_AUTO: begin
			if (light > LIGHT_ON_LEVEL)
				ctl_lamp = 1'b1;
			if (light < LIGHT_OFF_LEVEL)
				ctl_lamp = 1'b0;
		end
		MODE_MANUAL: begin
			apply_drive(cfg_manual);
		end
		MODE_TIMED: begin
			// Reaching the stop time ends the schedule.
			if (hour >= cfg_end_hour && minute >= cfg_end_minute) begin
				ctl_running = 1'b0;
				ctl_step    = WAIT_STEP;
			end
			if (ctl_running) begin
				if (ctl_step == WAIT_STEP) begin
					// Waiting: latch the start, begin once the hour leaves zero.
					ctl_start_minute = now;
					ctl_step = (hour == 0) ? WAIT_STEP : STEP_W'(0);
				end else if (ctl_step < SEGMENTS) begin
					slot = ctl_step;
					if (slot < HALF_SLOTS) begin
						apply_drive(cfg_power_first[POWER_W*slot +: POWER_W]);
						seg_minutes = cfg_duration_first[DUR_W*slot +: DUR_W];
					end else begin
						apply_drive(cfg_power_second[POWER_W*(slot-HALF_SLOTS) +: POWER_W]);
						seg_minutes = cfg_duration_second[DUR_W*(slot-HALF_SLOTS) +: DUR_W];
					end
					elapsed = (now + MINUTES_PER_DAY - ctl_start_minute % MINUTES_PER_DAY)
						% MINUTES_PER_DAY;
					if (elapsed >= seg_minutes) begin
						ctl_start_minute = now;
						if (slot + 1 >= SEGMENTS) begin
							ctl_step    = WAIT_STEP;
							ctl_running = 1'b0;
						end else begin
							ctl_step = slot + 1;
						end
					end
				end else begin
					ctl_step         = WAIT_STEP;
					ctl_start_minute = now;
				end
			end
		end
		default: begin
		end
		endcase
		// With the lamp off the reported power is zero; the drive is kept.
		if (!ctl_lamp)
			ctl_power = '0;
		r.lamp_power      = ctl_power;
		r.pwm_compare     = PWM_FULL - PWM_STEP * ctl_drive;
		r.dac_level       = DAC_STEP * ctl_drive;
		r.lamp_on         = ctl_lamp;
		r.segment_index   = ctl_step;
		r.schedule_active = ctl_running;
		return r;
	endfunction

	function automatic void check_field(string name, logic [15:0] expected_v,
			logic [15:0] actual_v);
		if (expected_v !== actual_v) begin
			error_count++;
			$error("%s: expected %0d, actual %0d", name, expected_v, actual_v);
		end
	endfunction

	// Compare every result beat with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				error_count++;
				$error("result beat arrived with no expected result");
			end else begin
				oldest_report = pending_reports.pop_front();
				check_field("lamp_power", oldest_report.lamp_power, lamp_power);
				check_field("pwm_compare", oldest_report.pwm_compare, pwm_compare);
				check_field("dac_level", oldest_report.dac_level, dac_level);
				check_field("lamp_on", oldest_report.lamp_on, lamp_on);
				check_field("segment_index", oldest_report.segment_index, segment_index);
				check_field("schedule_active", oldest_report.schedule_active,
					schedule_active);
			end
		end
	end

	// Send one tick beat, after a random idle gap, and predict its result.
	task automatic send_tick(input logic [HOUR_W-1:0] hour, input logic [MIN_W-1:0] minute,
			input logic [LIGHT_W-1:0] light, input logic arm);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		clock_hour     <= hour;
		clock_minute   <= minute;
		light_level    <= light;
		start_schedule <= arm;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_reports.push_back(predict_tick(hour, minute, light, arm));
	endtask

	// Write one configuration register and mirror it in the predictor.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
		CFG_WORK_MODE:       cfg_mode            = mode_t'(value[MODE_W-1:0]);
		CFG_MANUAL_POWER:    cfg_manual          = value[POWER_W-1:0];
		CFG_POWER_FIRST:     cfg_power_first     = value[PWR_TABLE_W-1:0];
		CFG_POWER_SECOND:    cfg_power_second    = value[PWR_TABLE_W-1:0];
		CFG_DURATION_FIRST:  cfg_duration_first  = value[DUR_TABLE_W-1:0];
		CFG_DURATION_SECOND: cfg_duration_second = value[DUR_TABLE_W-1:0];
		CFG_END_HOUR:        cfg_end_hour        = value[HOUR_W-1:0];
		CFG_END_MINUTE:      cfg_end_minute      = value[MIN_W-1:0];
		default: begin
		end
		endcase
		@(posedge clk);
	endtask

	// Stop sending and let every expected result drain out of the block.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Program the timed schedule: tables, stop time and mode.
	task automatic program_schedule(input sched_flavor_t flavor);
		logic [PWR_TABLE_W-1:0] pwr_a;
		logic [PWR_TABLE_W-1:0] pwr_b;
		logic [DUR_TABLE_W-1:0] dur_a;
		logic [DUR_TABLE_W-1:0] dur_b;
		int                     pick;
		int                     k;
		for (k = 0; k < HALF_SLOTS; k++) begin
			pwr_a[POWER_W*k +: POWER_W] = $urandom_range(0, 127);
			pwr_b[POWER_W*k +: POWER_W] = $urandom_range(0, 127);
			// Mostly short segments so that the schedule moves along.
			pick = $urandom_range(99);
			dur_a[DUR_W*k +: DUR_W] = (pick < 70) ? $urandom_range(0, 4) :
				(pick < 90) ? $urandom_range(5, 60) : $urandom_range(0, 2047);
			pick = $urandom_range(99);
			dur_b[DUR_W*k +: DUR_W] = (pick < 70) ? $urandom_range(0, 4) :
				(pick < 90) ? $urandom_range(5, 60) : $urandom_range(0, 2047);
		end
		case (flavor)
		SCHED_ALL_MAX: begin
			write_reg(CFG_POWER_FIRST, '1);
			write_reg(CFG_POWER_SECOND, '1);
			write_reg(CFG_DURATION_FIRST, '1);
			write_reg(CFG_DURATION_SECOND, '1);
			write_reg(CFG_END_HOUR, 23);
			write_reg(CFG_END_MINUTE, 59);
		end
		SCHED_ALL_MIN: begin
			write_reg(CFG_POWER_FIRST, '0);
			write_reg(CFG_POWER_SECOND, '0);
			write_reg(CFG_DURATION_FIRST, '0);
			write_reg(CFG_DURATION_SECOND, '0);
			write_reg(CFG_END_HOUR, 0);
			write_reg(CFG_END_MINUTE, 0);
		end
		default: begin
			write_reg(CFG_POWER_FIRST, CFG_DATA_W'(pwr_a));
			write_reg(CFG_POWER_SECOND, CFG_DATA_W'(pwr_b));
			write_reg(CFG_DURATION_FIRST, CFG_DATA_W'(dur_a));
			write_reg(CFG_DURATION_SECOND, CFG_DATA_W'(dur_b));
			write_reg(CFG_END_HOUR, ($urandom_range(99) < 80) ?
				$urandom_range(18, 23) : $urandom_range(0, 23));
			write_reg(CFG_END_MINUTE, $urandom_range(0, 59));
		end
		endcase
		write_reg(CFG_WORK_MODE, CFG_DATA_W'(MODE_TIMED));
	endtask

	// A running clock with occasional arming, plus some out-of-order noise.
	task automatic send_schedule_ticks(input int count);
		int i;
		if ($urandom_range(99) < 30)
			day_minute = $urandom_range(1420, 1439);
		else
			day_minute = $urandom_range(0, 1439);
		for (i = 0; i < count; i++) begin
			if ($urandom_range(99) < 10) begin
				send_tick($urandom_range(0, 23), $urandom_range(0, 59),
					$urandom_range(0, 4095), $urandom_range(0, 1));
			end else begin
				day_minute = (day_minute + $urandom_range(0, 3)) % MINUTES_PER_DAY;
				send_tick(day_minute / MINUTES_PER_HOUR, day_minute % MINUTES_PER_HOUR,
					$urandom_range(0, 4095), (i == 0) || ($urandom_range(99) < 4));
			end
		end
	endtask

	// Automatic mode: hysteresis edges, and arming outside the timed mode.
	task automatic test_auto_hysteresis();
		send_tick(0, 0, 4095, 1'b0);
		send_tick(12, 30, 1000, 1'b0);
		send_tick(12, 31, 920, 1'b0);
		send_tick(12, 32, 919, 1'b0);
		send_tick(23, 59, 1001, 1'b1);
		wait_idle();
	endtask

	// Manual mode: full, saturated, zero and middle power.
	task automatic test_manual_power();
		write_reg(CFG_WORK_MODE, CFG_DATA_W'(MODE_MANUAL));
		write_reg(CFG_MANUAL_POWER, 100);
		send_tick(8, 0, 0, 1'b0);
		wait_idle();
		write_reg(CFG_MANUAL_POWER, 127);
		send_tick(8, 1, 4095, 1'b0);
		wait_idle();
		write_reg(CFG_MANUAL_POWER, 0);
		send_tick(8, 2, 2000, 1'b0);
		wait_idle();
		write_reg(CFG_MANUAL_POWER, 55);
		send_tick(8, 3, 500, 1'b0);
		wait_idle();
	endtask

	// The unused mode only arms the schedule on request and clears the reported power when the lamp is off.
	task automatic test_mode_three();
		write_reg(CFG_WORK_MODE, CFG_DATA_W'(MODE_NONE));
		send_tick(9, 15, 0, 1'b1);
		wait_idle();
	endtask

	// Timed mode: wait at hour zero, all ten segments, then the stop time.
	task automatic test_timed_schedule();
		int k;
		write_reg(CFG_POWER_FIRST, '1);
		write_reg(CFG_POWER_SECOND, {7'd127, 7'd99, 7'd1, 7'd100, 7'd0});
		write_reg(CFG_DURATION_FIRST, '0);
		write_reg(CFG_DURATION_SECOND, '0);
		write_reg(CFG_END_HOUR, 23);
		write_reg(CFG_END_MINUTE, 59);
		write_reg(CFG_WORK_MODE, CFG_DATA_W'(MODE_TIMED));
		send_tick(0, 5, 100, 1'b1);
		send_tick(0, 6, 100, 1'b0);
		send_tick(1, 0, 100, 1'b0);
		for (k = 1; k <= SEGMENTS; k++)
			send_tick(1, k, 3000, 1'b0);
		send_tick(2, 0, 0, 1'b1);
		send_tick(23, 59, 0, 1'b0);
		wait_idle();
	endtask

	// Random schedules under the current traffic profile.
	task automatic test_random_schedule(input int profile);
		int c;
		for (c = 0; c < 5; c++) begin
			program_schedule((c == 0) ? sched_flavor_t'(profile % 3) : SCHED_RANDOM);
			send_schedule_ticks(50);
			wait_idle();
		end
	endtask

	// Random modes with light levels around the switching thresholds.
	task automatic test_random_modes();
		int c;
		int i;
		for (c = 0; c < 3; c++) begin
			write_reg(CFG_WORK_MODE, ($urandom_range(99) < 90) ?
				$urandom_range(0, 2) : CFG_DATA_W'(MODE_NONE));
			write_reg(CFG_MANUAL_POWER, $urandom_range(0, 127));
			for (i = 0; i < 25; i++)
				send_tick($urandom_range(0, 23), $urandom_range(0, 59),
					($urandom_range(1) != 0) ? $urandom_range(0, 4095) :
					$urandom_range(880, 1040), $urandom_range(99) < 10);
			wait_idle();
		end
	endtask

	// Hold the output side off long enough that the block stalls its input.
	task automatic test_backpressure();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		program_schedule(SCHED_RANDOM);
		hold_request = 300;
		send_schedule_ticks(40);
		wait_idle();
	endtask

	initial begin
		int p;
		cfg_mode            = MODE_AUTO;
		cfg_manual          = '0;
		cfg_power_first     = '0;
		cfg_power_second    = '0;
		cfg_duration_first  = '0;
		cfg_duration_second = '0;
		cfg_end_hour        = '0;
		cfg_end_minute      = '0;
		ctl_step            = WAIT_STEP;
		ctl_running         = 1'b0;
		ctl_start_minute    = '0;
		ctl_lamp            = 1'b0;
		ctl_power           = '0;
		ctl_drive           = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_auto_hysteresis();
		test_manual_power();
		test_mode_three();
		test_timed_schedule();
		for (p = 0; p < 4; p++) begin
			src_idle_pct   = SRC_IDLE_PCT[p];
			sink_stall_pct = SINK_STALL_PCT[p];
			test_random_schedule(p);
			test_random_modes();
		end
		test_backpressure();

		wait_idle();
		repeat (8) @(posedge clk);
		if (pending_reports.size() != 0)
			error_count++;
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
